FILE: hw/rtl/rate_limited_check_valve_position_macros.svh
// Assertion macros for the valve position checker.
`ifndef RATE_LIMITED_CHECK_VALVE_POSITION_MACROS_SVH
`define RATE_LIMITED_CHECK_VALVE_POSITION_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RLCV_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("valve position check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define RLCV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("valve position check failed");

`endif

FILE: hw/rtl/rlcv_pkg.sv
// Types and constants shared by the valve position controller, datapath and checker.
`default_nettype none
package rlcv_pkg;

	localparam int unsigned POS_W      = 17;
	localparam int unsigned PRESS_W    = 32;
	localparam int unsigned DT_W       = 24;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Fully open position in Q1.16
	localparam logic [POS_W-1:0] FULL_OPEN = 17'h10000;

	// Quotient bits of the ramp divide
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_PRESSURE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PRESSURE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STUCK_ENABLE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TO_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TO_POSITION = 3'd5;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic init;
		logic step;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_div;
	} sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rlcv_ctrl.sv
// Sequencer for one tick: load, setup, divide steps if needed, commit to the output word.
`default_nettype none
module rlcv_ctrl
	import rlcv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             in_acc;
	logic             out_free;
	logic             commit;

	// Handshake decode
	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == ST_FIN) && out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Issue commands from the current state
	assign cmd.load   = in_acc;
	assign cmd.init   = (state_q == ST_CALC);
	assign cmd.step   = (state_q == ST_DIV);
	assign cmd.commit = commit;

	// Hold state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_CALC;
				end
				ST_CALC: begin
					cnt_q   <= '0;
					state_q <= sts.need_div ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/rlcv_dp.sv
// Datapath: settings, rate product, ramp divider and position clamp.
`default_nettype none
module rlcv_dp
	import rlcv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [PRESS_W-1:0]    pressure_drop,
	input  wire logic [DT_W-1:0]       time_step,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output logic [POS_W-1:0]           valve_position
);

	localparam int unsigned PROD_W = PRESS_W + DT_W;

	// Settings
	logic signed [PRESS_W-1:0] close_q;
	logic signed [PRESS_W-1:0] open_q;
	logic [PRESS_W-1:0]        rate_q;
	logic                      stuck_q;
	logic                      fail_q;
	logic [POS_W-1:0]          ftp_q;

	// Position state
	logic [POS_W-1:0] pos_q;

	// Working registers
	logic signed [PRESS_W-1:0] drop_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic [PRESS_W-1:0]        rem_q;
	logic [PRESS_W-1:0]        den_q;
	logic [POS_W-1:0]          target_q;
	logic [POS_W-1:0]          delta_q;

	logic                      ge_open;
	logic                      le_close;
	logic [PRESS_W:0]          num_diff;
	logic [PRESS_W:0]          den_diff;
	logic [PROD_W-17:0]        md;
	logic [POS_W-1:0]          delta_c;
	logic [PRESS_W:0]          rem_sh;
	logic                      q_bit;
	logic [POS_W:0]            hi_sum;
	logic [POS_W-1:0]          hi_c;
	logic [POS_W-1:0]          lo_c;
	logic [POS_W-1:0]          ramp_pos;
	logic [POS_W-1:0]          ftp_clamp;
	logic [POS_W-1:0]          new_pos;

	// Compare the drop against the thresholds and form the ramp operands
	always_comb begin
		ge_open  = (drop_s1 >= open_q);
		le_close = (drop_s1 <= close_q);
		num_diff = {drop_s1[PRESS_W-1], drop_s1} - {close_q[PRESS_W-1], close_q};
		den_diff = {open_q[PRESS_W-1], open_q} - {close_q[PRESS_W-1], close_q};
		sts.need_div = !stuck_q && !fail_q && !ge_open && !le_close;
	end

	// Saturate the rate product to one full stroke
	assign md      = prod_s1[PROD_W-1:16];
	assign delta_c = (md > (PROD_W-16)'(FULL_OPEN)) ? FULL_OPEN : md[POS_W-1:0];

	// One restoring divide step
	assign rem_sh = {rem_q, 1'b0};
	assign q_bit  = (rem_sh >= {1'b0, den_q});

	// Clamp the ramp target around the old position; stuck or fail-to wins
	always_comb begin
		hi_sum = {1'b0, pos_q} + {1'b0, delta_q};
		hi_c   = (hi_sum > {1'b0, FULL_OPEN}) ? FULL_OPEN : hi_sum[POS_W-1:0];
		lo_c   = (pos_q > delta_q) ? (pos_q - delta_q) : '0;
		ramp_pos = (target_q > hi_c) ? hi_c : target_q;
		if (ramp_pos < lo_c) ramp_pos = lo_c;
		ftp_clamp = (ftp_q > FULL_OPEN) ? FULL_OPEN : ftp_q;
		if (stuck_q) begin
			new_pos = pos_q;
		end else if (fail_q) begin
			new_pos = ftp_clamp;
		end else begin
			new_pos = ramp_pos;
		end
	end

	// Write settings and advance the position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= '0;
			open_q  <= '0;
			rate_q  <= '0;
			stuck_q <= 1'b0;
			fail_q  <= 1'b0;
			ftp_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_CLOSE_PRESSURE:   close_q <= cfg_data;
					CFG_OPEN_PRESSURE:    open_q  <= cfg_data;
					CFG_RATE_LIMIT:       rate_q  <= cfg_data;
					CFG_STUCK_ENABLE:     stuck_q <= cfg_data[0];
					CFG_FAIL_TO_ENABLE:   fail_q  <= cfg_data[0];
					CFG_FAIL_TO_POSITION: ftp_q   <= cfg_data[POS_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) pos_q <= new_pos;
		end
	end

	// Load the word, set up the divide, then shift in quotient bits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			drop_s1 <= pressure_drop;
			prod_s1 <= PROD_W'(rate_q) * PROD_W'(time_step);
		end
		if (cmd.init) begin
			rem_q    <= num_diff[PRESS_W-1:0];
			den_q    <= den_diff[PRESS_W-1:0];
			target_q <= ge_open ? FULL_OPEN : '0;
			delta_q  <= delta_c;
		end
		if (cmd.step) begin
			rem_q    <= q_bit ? PRESS_W'(rem_sh - {1'b0, den_q}) : rem_sh[PRESS_W-1:0];
			target_q <= {target_q[POS_W-2:0], q_bit};
		end
	end

	assign valve_position = pos_q;

endmodule
`default_nettype wire

FILE: hw/rtl/rate_limited_check_valve_position.sv
// Rate-limited check valve position: one position update per accepted tick.
//
// Input channel: in_valid/in_stall carry a pressure drop (Q16.16 signed)
// and a time step (Q8.16). Output channel: out_valid/out_stall carry the
// new valve position (Q1.16, 65536 fully open), one word per input word.
// Settings are written through cfg_wr_en/cfg_index/cfg_data while idle.
//
// An accepted tick is loaded and set up; a tick inside the ramp band
// then runs 16 radix-2 restoring divider steps, while ticks at the end
// stops, stuck or forced to the fail-to position skip the divider. The
// result is committed once the output word is free. No new tick is
// accepted before the block is idle again after that commit.
//
// The output word is the position register itself. A finished word may
// wait under out_stall while the next tick is accepted and worked on; the
// commit of that next tick waits until the waiting word is taken.
// Reset clears all settings and closes the valve (position 0).
`default_nettype none
module rate_limited_check_valve_position
	import rlcv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PRESS_W-1:0]    pressure_drop,
	input  wire logic [DT_W-1:0]       time_step,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [POS_W-1:0]           valve_position
);

	cmd_t cmd;
	sts_t sts;

	// Sequence each tick
	rlcv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Compute the new position
	rlcv_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pressure_drop  (pressure_drop),
		.time_step      (time_step),
		.cmd            (cmd),
		.sts            (sts),
		.valve_position (valve_position)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/rlcv_checker.sv
// Port-level checker for the valve position block, bound to the top level.
`default_nettype none
`include "rate_limited_check_valve_position_macros.svh"
module rlcv_checker
	import rlcv_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [POS_W-1:0]      valve_position
);

	// A stalled output word stays put
	`RLCV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(valve_position))

	// Position never exceeds fully open
	`RLCV_ASSERT_IMPL(a_pos_range, out_valid, valve_position <= FULL_OPEN)

	// An accepted tick makes the block busy
	`RLCV_ASSERT_NEXT(a_busy_after_acc, in_valid && !in_stall, in_stall)

	// A new word only comes out of a busy tick
	`RLCV_ASSERT_IMPL(a_out_from_tick, $rose(out_valid), $past(in_stall))

endmodule

bind rate_limited_check_valve_position rlcv_checker u_rlcv_checker (.*);
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking bench for the rate-limited check valve position block.
module tb_top
	import rlcv_pkg::*;
();

	localparam logic [31:0] PRESS_ONE       = 32'h0001_0000;
	localparam logic [31:0] PRESS_MINUS_ONE = 32'hFFFF_0000;
	localparam logic [31:0] PRESS_MIN       = 32'h8000_0000;
	localparam logic [31:0] PRESS_MAX       = 32'h7FFF_FFFF;
	localparam logic [23:0] DT_MAX          = 24'hFF_FFFF;
	localparam int unsigned DRAIN_CYCLES    = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [PRESS_W-1:0]    pressure_drop;
	logic [DT_W-1:0]       time_step;
	logic                  out_valid;
	logic                  out_stall;
	logic [POS_W-1:0]      valve_position;

	// Shadow copy of the settings and the valve position
	logic signed [31:0] set_close;
	logic signed [31:0] set_open;
	logic [31:0]        set_rate;
	logic               set_stuck;
	logic               set_fail_en;
	logic [16:0]        set_fail_pos;
	logic [16:0]        tracked_position;

	logic [16:0] pending_positions[$];
	int unsigned mismatch_count = 0;
	logic        steady = 1'b0;

	rate_limited_check_valve_position dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pressure_drop (pressure_drop),
		.time_step     (time_step),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.valve_position(valve_position)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Pick an idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Compute the position that one tick leaves behind
	function automatic logic [16:0] next_position(input logic signed [31:0] drop,
	                                              input logic [23:0] dt);
		longint          num;
		longint          band_lo;
		longint          band_hi;
		longint unsigned step_max;
		logic [16:0]     goal;
		logic [16:0]     delta;
		logic [16:0]     floor_pos;
		logic [16:0]     ceil_pos;
		if (set_stuck) return tracked_position;
		if (set_fail_en) return (set_fail_pos > FULL_OPEN) ? FULL_OPEN : set_fail_pos;
		band_lo = longint'(set_close);
		band_hi = longint'(set_open);
		// Open test first, so an inverted band never divides
		if (longint'(drop) >= band_hi) begin
			goal = FULL_OPEN;
		end else if (longint'(drop) <= band_lo) begin
			goal = '0;
		end else begin
			num  = (longint'(drop) - band_lo) * 65536;
			goal = 17'(num / (band_hi - band_lo));
		end
		// Limit the move to rate * dt, saturated at full travel
		step_max  = (64'(set_rate) * 64'(dt)) >> 16;
		delta     = (step_max > 64'(FULL_OPEN)) ? FULL_OPEN : 17'(step_max);
		floor_pos = (tracked_position > delta) ? tracked_position - delta : '0;
		ceil_pos  = (18'(tracked_position) + 18'(delta) > 18'(FULL_OPEN)) ?
		            FULL_OPEN : tracked_position + delta;
		if (goal > ceil_pos) goal = ceil_pos;
		if (goal < floor_pos) goal = floor_pos;
		return goal;
	endfunction

	// Write all six settings on consecutive cycles, then mirror them
	task automatic write_settings(input logic [31:0] close_p, input logic [31:0] open_p,
	                              input logic [31:0] rate, input logic stuck,
	                              input logic fail_en, input logic [16:0] fail_pos);
		logic [CFG_IDX_W-1:0]  idx_list[6];
		logic [CFG_DATA_W-1:0] val_list[6];
		idx_list = '{CFG_CLOSE_PRESSURE, CFG_OPEN_PRESSURE, CFG_RATE_LIMIT,
		             CFG_STUCK_ENABLE, CFG_FAIL_TO_ENABLE, CFG_FAIL_TO_POSITION};
		val_list = '{close_p, open_p, rate, 32'(stuck), 32'(fail_en), 32'(fail_pos)};
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= val_list[i];
			@(posedge clk);
		end
		cfg_wr_en    <= 1'b0;
		set_close    = close_p;
		set_open     = open_p;
		set_rate     = rate;
		set_stuck    = stuck;
		set_fail_en  = fail_en;
		set_fail_pos = fail_pos;
	endtask

	// Offer one tick word; keep valid high on return for a back-to-back word
	task automatic send_tick(input logic [31:0] drop, input logic [23:0] dt);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		pressure_drop <= drop;
		time_step     <= dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracked_position = next_position(drop, dt);
		pending_positions.push_back(tracked_position);
	endtask

	// Drop valid and wait until every expected position has come out
	task automatic wait_for_positions();
		in_valid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Default settings: equal thresholds and zero rate keep the valve closed
	task automatic test_closed_at_reset();
		send_tick(PRESS_MAX, DT_MAX);
		send_tick(PRESS_MIN, 24'h00_0001);
		wait_for_positions();
	endtask

	// Ramp ends, midpoint and the one-step rate limit inside a +-1.0 band
	task automatic test_ramp_band();
		write_settings(PRESS_MINUS_ONE, PRESS_ONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0);
		send_tick(32'h0, DT_MAX);
		send_tick(PRESS_ONE, DT_MAX);
		send_tick(PRESS_ONE - 1, DT_MAX);
		send_tick(PRESS_MINUS_ONE + 1, DT_MAX);
		send_tick(PRESS_MINUS_ONE, DT_MAX);
		send_tick(PRESS_MAX, 24'h00_0001);
		send_tick(PRESS_MIN, 24'h00_0000);
		send_tick(PRESS_MIN, DT_MAX);
		wait_for_positions();
	endtask

	// Widest possible band: full-range divisor and saturated step
	task automatic test_wide_band();
		write_settings(PRESS_MIN, PRESS_MAX, PRESS_ONE, 1'b0, 1'b0, 17'h1_FFFF);
		send_tick(32'h0, 24'h00_8000);
		send_tick(PRESS_MAX, 24'h00_8000);
		send_tick(PRESS_MIN + 1, 24'h80_0000);
		wait_for_positions();
	endtask

	// Fail-to clamp, stuck over fail-to, stuck alone and zero rate
	task automatic test_fail_and_stuck();
		write_settings(PRESS_MINUS_ONE, PRESS_ONE, 32'hFFFF_FFFF, 1'b0, 1'b1, 17'h1_FFFF);
		send_tick(PRESS_MIN, 24'h00_0000);
		wait_for_positions();
		write_settings(PRESS_MINUS_ONE, PRESS_ONE, 32'hFFFF_FFFF, 1'b0, 1'b1, 17'd0);
		send_tick(PRESS_MAX, DT_MAX);
		wait_for_positions();
		write_settings(PRESS_MINUS_ONE, PRESS_ONE, 32'hFFFF_FFFF, 1'b1, 1'b1, FULL_OPEN);
		send_tick(PRESS_MAX, DT_MAX);
		wait_for_positions();
		write_settings(PRESS_MINUS_ONE, PRESS_ONE, 32'hFFFF_FFFF, 1'b1, 1'b0, FULL_OPEN);
		send_tick(PRESS_ONE, DT_MAX);
		wait_for_positions();
		write_settings(PRESS_MINUS_ONE, PRESS_ONE, 32'h0, 1'b0, 1'b0, FULL_OPEN);
		send_tick(PRESS_ONE, DT_MAX);
		wait_for_positions();
	endtask

	// Open threshold below close: open test wins, everything else is closed
	task automatic test_inverted_band();
		write_settings(32'h0002_0000, 32'hFFFE_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0);
		send_tick(32'hFFFD_FFFF, DT_MAX);
		send_tick(32'hFFFE_0000, DT_MAX);
		send_tick(32'h0, DT_MAX);
		send_tick(PRESS_MIN, DT_MAX);
		wait_for_positions();
	endtask

	// Random settings per phase, ticks mostly inside the ramp band
	task automatic test_random_ticks();
		int unsigned n;
		int unsigned r;
		logic [31:0] close_p;
		logic [31:0] open_p;
		logic [31:0] band;
		logic [31:0] rate;
		logic [31:0] drop;
		logic [23:0] dt;
		logic        stuck;
		logic        fail_en;
		logic [16:0] fail_pos;
		for (int phase = 0; phase < 16; phase++) begin
			steady = (phase == 5) || (phase == 12);
			// Band: narrow around zero, full range, random, tiny or inverted
			r       = $urandom_range(0, 9);
			close_p = $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
			band    = $urandom_range(1, 32'h0004_0000);
			if (r == 0) begin
				close_p = PRESS_MIN;
				band    = 32'hFFFF_FFFF;
			end else if (r == 1) begin
				close_p = $urandom();
				band    = $urandom();
			end else if (r == 2) begin
				band = $urandom_range(1, 16);
			end else if (r == 3) begin
				band = 32'h0 - $urandom_range(0, 32'h0004_0000);
			end
			open_p = close_p + band;
			// Rate: zero, max, anything, or slow enough to bite
			r = $urandom_range(0, 9);
			if (r == 0) rate = '0;
			else if (r == 1) rate = '1;
			else if (r < 4) rate = $urandom();
			else rate = $urandom_range(1, 32'h0004_0000);
			stuck   = ($urandom_range(0, 11) == 0);
			fail_en = ($urandom_range(0, 7) == 0);
			r = $urandom_range(0, 5);
			if (r == 0) fail_pos = '0;
			else if (r == 1) fail_pos = FULL_OPEN;
			else if (r == 2) fail_pos = '1;
			else fail_pos = 17'($urandom());
			write_settings(close_p, open_p, rate, stuck, fail_en, fail_pos);

			n = $urandom_range(80, 110);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					drop = close_p + $urandom_range(0, band);
				end else if (r < 82) begin
					case ($urandom_range(0, 3))
						0: drop = close_p;
						1: drop = open_p;
						2: drop = close_p + 1;
						default: drop = open_p - 1;
					endcase
				end else begin
					drop = $urandom();
				end
				r = $urandom_range(0, 99);
				if (r < 65) dt = $urandom_range(0, 24'h00_2000);
				else if (r < 75) dt = '0;
				else if (r < 80) dt = DT_MAX;
				else dt = 24'($urandom());
				send_tick(drop, dt);
			end
			wait_for_positions();
		end
		steady = 1'b0;
	endtask

	// Stall the output side in random bursts
	initial begin
		int unsigned run_len;
		int unsigned hold_len;
		out_stall <= 1'b0;
		forever begin
			run_len = $urandom_range(1, 24);
			repeat (run_len) @(posedge clk);
			hold_len = pick_gap();
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted position word with the oldest expectation
	always @(posedge clk) begin : check_positions
		logic [16:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_positions.size() == 0) begin
				$display("%0t: unexpected valve_position word, expected none, actual %0d",
				         $time, valve_position);
				mismatch_count++;
			end else begin
				want = pending_positions.pop_front();
				if (valve_position !== want) begin
					$display("%0t: valve_position mismatch, expected %0d, actual %0d",
					         $time, want, valve_position);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= CFG_CLOSE_PRESSURE;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		pressure_drop <= '0;
		time_step     <= '0;
		set_close        = '0;
		set_open         = '0;
		set_rate         = '0;
		set_stuck        = 1'b0;
		set_fail_en      = 1'b0;
		set_fail_pos     = '0;
		tracked_position = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_closed_at_reset();
		test_ramp_band();
		test_wide_band();
		test_fail_and_stuck();
		test_inverted_band();
		test_random_ticks();
		wait_for_positions();

		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#24_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
